// File: rtl/core/afsk_pkg.sv
// shared types and constants for the afsk nrzi half-cycle generator
`timescale 1ns / 1ps

package afsk_pkg;

    // fixed field widths
    localparam int TIME_W   = 32;
    localparam int WIDTH_W  = 16;
    localparam int COUNT_W  = 16;
    localparam int CFG_IDX_W = 2;

    // input selector codes
    localparam logic [1:0] FUNC_DATA  = 2'd0;
    localparam logic [1:0] FUNC_FLUSH = 2'd1;
    localparam logic [1:0] FUNC_START = 2'd2;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_BIT_TIME       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MARK_HALF      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPACE_HALF     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_CAPACITY = 2'd3;

    // register reset values
    localparam logic [TIME_W-1:0]  BIT_TIME_RST       = 32'd54613333;
    localparam logic [TIME_W-1:0]  MARK_HALF_RST      = 32'd27306667;
    localparam logic [TIME_W-1:0]  SPACE_HALF_RST     = 32'd14894545;
    localparam logic [COUNT_W-1:0] PULSE_CAPACITY_RST = 16'd4096;

    // input item
    typedef struct packed {
        logic [1:0] func;
        logic       bit_req;
    } in_item_t;

    // result item
    typedef struct packed {
        logic [WIDTH_W-1:0] pulse_width;
        logic               last;
        logic               overflow;
    } out_item_t;

    // classified command from the front end
    typedef enum logic [1:0] {
        CMD_DATA,
        CMD_FLUSH,
        CMD_START
    } cmd_kind_e;

    typedef struct packed {
        cmd_kind_e kind;
        logic      bit_val;
    } cmd_t;

    // configuration bundle
    typedef struct packed {
        logic [TIME_W-1:0]  bit_time;
        logic [TIME_W-1:0]  mark_half;
        logic [TIME_W-1:0]  space_half;
        logic [COUNT_W-1:0] pulse_capacity;
    } cfg_t;

endpackage

// File: rtl/core/afsk_queue.sv
// small register fifo with valid/ready on both sides
`timescale 1ns / 1ps

module afsk_queue #(
    parameter type item_t = logic,
    parameter int  DEPTH  = 2
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output item_t out_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    item_t           store_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CNTW-1:0] count_reg;
    logic [CNTW-1:0] count_next;
    logic            push;
    logic            pop;

    assign in_ready  = (count_reg != CNTW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = store_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // payload storage, no reset
    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// File: rtl/core/afsk_front.sv
// input front end: decodes the selector and queues commands for the engine
`timescale 1ns / 1ps

module afsk_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  afsk_pkg::in_item_t s_data,
    output logic               cmd_valid,
    input  logic               cmd_ready,
    output afsk_pkg::cmd_t     cmd_data
);

    afsk_pkg::cmd_t decoded;
    logic           known;

    // classify the selector, the unused code is dropped at the door
    always_comb begin
        decoded.kind    = afsk_pkg::CMD_DATA;
        decoded.bit_val = s_data.bit_req;
        known           = 1'b1;
        case (s_data.func)
            afsk_pkg::FUNC_DATA:  decoded.kind = afsk_pkg::CMD_DATA;
            afsk_pkg::FUNC_FLUSH: decoded.kind = afsk_pkg::CMD_FLUSH;
            afsk_pkg::FUNC_START: decoded.kind = afsk_pkg::CMD_START;
            default:              known        = 1'b0;
        endcase
    end

    // command queue toward the engine
    afsk_queue #(
        .item_t (afsk_pkg::cmd_t),
        .DEPTH  (2)
    ) u_cmd_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid && known),
        .in_ready  (s_ready),
        .in_data   (decoded),
        .out_valid (cmd_valid),
        .out_ready (cmd_ready),
        .out_data  (cmd_data)
    );

endmodule

// File: rtl/core/afsk_engine.sv
// back end: nrzi tone tracking, half-cycle emission and carried rounding
`timescale 1ns / 1ps

module afsk_engine #(
    parameter int FRAC_BITS  = 16,
    parameter int MAX_PULSES = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  afsk_pkg::cfg_t      cfg,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  afsk_pkg::cmd_t      cmd_data,
    output logic                res_valid,
    input  logic                res_ready,
    output afsk_pkg::out_item_t res_data
);

    localparam int TW   = afsk_pkg::TIME_W;
    localparam int WW   = afsk_pkg::WIDTH_W;
    localparam int CNW  = afsk_pkg::COUNT_W;
    localparam int CW   = FRAC_BITS + 2;
    localparam int VW   = TW + 2;
    localparam int RW   = (VW + 1 > WW + FRAC_BITS + 1) ? VW + 1 : WW + FRAC_BITS + 1;
    localparam int AW   = $clog2(MAX_PULSES + 1);
    localparam logic [FRAC_BITS-1:0] HALF_ONE = {1'b1, {(FRAC_BITS - 1){1'b0}}};
    localparam logic [CW-1:0] CARRY_MAX = {1'b0, {(FRAC_BITS + 1){1'b1}}};
    localparam logic [CW-1:0] CARRY_MIN = {1'b1, {(FRAC_BITS + 1){1'b0}}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PEND,
        ST_LOOP,
        ST_DONE
    } state_t;

    state_t          state_reg, state_next;
    logic            tone_mark_reg, tone_mark_next;
    logic [TW-1:0]   cur_half_reg, cur_half_next;
    logic [TW-1:0]   pend_time_reg, pend_time_next;
    logic [CW-1:0]   carry_reg, carry_next;
    logic [CNW-1:0]  emitted_reg, emitted_next;
    logic            ovf_reg, ovf_next;
    logic [TW:0]     accum_reg, accum_next;
    logic [TW-1:0]   tgt_half_reg, tgt_half_next;
    logic            flush_mode_reg, flush_mode_next;
    logic [AW-1:0]   attempts_reg, attempts_next;
    logic            item_ovf_reg, item_ovf_next;
    logic            held_valid_reg, held_valid_next;
    logic [WW-1:0]   held_width_reg, held_width_next;

    logic            new_tone;
    logic [TW-1:0]   new_half;
    logic [TW-1:0]   att_value;
    logic            att_block;
    logic            loop_more;
    logic            attempting;
    logic            proceed;
    logic [VW-1:0]   v;
    logic [VW-1:0]   whole_raw;
    logic [VW-1:0]   whole_rnd;
    logic            round_up;
    logic [WW-1:0]   rnd_width;
    logic [RW-1:0]   rem;
    logic            rem_hi;
    logic            rem_lo;
    logic [CW-1:0]   rnd_carry;

    // tone selected by the incoming bit
    assign new_tone = cmd_data.bit_val ? tone_mark_reg : !tone_mark_reg;
    assign new_half = new_tone ? cfg.mark_half : cfg.space_half;

    // emission attempt operand and limits
    assign att_value  = (state_reg == ST_PEND) ? pend_time_reg : cur_half_reg;
    assign att_block  = (attempts_reg >= AW'(MAX_PULSES)) ||
                        (emitted_reg >= cfg.pulse_capacity);
    assign loop_more  = (accum_reg >= {1'b0, cur_half_reg});
    assign attempting = (state_reg == ST_PEND) || ((state_reg == ST_LOOP) && loop_more);

    // carried round half to even
    always_comb begin
        v         = {2'b00, att_value} + {{(VW - CW){carry_reg[CW-1]}}, carry_reg};
        whole_raw = VW'($signed(v) >>> FRAC_BITS);
        round_up  = (v[FRAC_BITS-1:0] > HALF_ONE) ||
                    ((v[FRAC_BITS-1:0] == HALF_ONE) && whole_raw[0]);
        whole_rnd = whole_raw + VW'(round_up);
        if (whole_rnd[VW-1]) begin
            rnd_width = '0;
        end else if (|whole_rnd[VW-2:WW]) begin
            rnd_width = '1;
        end else begin
            rnd_width = whole_rnd[WW-1:0];
        end
        rem    = {{(RW - VW){v[VW-1]}}, v} -
                 {{(RW - WW - FRAC_BITS){1'b0}}, rnd_width, {FRAC_BITS{1'b0}}};
        rem_hi = !rem[RW-1] && (|rem[RW-2:FRAC_BITS+1]);
        rem_lo = rem[RW-1] && !(&rem[RW-2:FRAC_BITS+1]);
        if (rem_hi) begin
            rnd_carry = CARRY_MAX;
        end else if (rem_lo) begin
            rnd_carry = CARRY_MIN;
        end else begin
            rnd_carry = rem[CW-1:0];
        end
    end

    // result transfer: a held width moves out when a newer one replaces it, the last one at item close
    always_comb begin
        res_valid = 1'b0;
        res_data  = '{pulse_width: held_width_reg, last: 1'b0, overflow: 1'b0};
        if (attempting && !att_block && (rnd_width != '0) && held_valid_reg) begin
            res_valid = 1'b1;
        end else if ((state_reg == ST_DONE) && (held_valid_reg || item_ovf_reg)) begin
            res_valid = 1'b1;
            res_data  = '{pulse_width: held_valid_reg ? held_width_reg : '0,
                          last: 1'b1, overflow: item_ovf_reg};
        end
    end

    assign proceed   = !res_valid || res_ready;
    assign cmd_ready = (state_reg == ST_IDLE);

    // sequencer
    always_comb begin
        state_next      = state_reg;
        tone_mark_next  = tone_mark_reg;
        cur_half_next   = cur_half_reg;
        pend_time_next  = pend_time_reg;
        carry_next      = carry_reg;
        emitted_next    = emitted_reg;
        ovf_next        = ovf_reg;
        accum_next      = accum_reg;
        tgt_half_next   = tgt_half_reg;
        flush_mode_next = flush_mode_reg;
        attempts_next   = attempts_reg;
        item_ovf_next   = item_ovf_reg;
        held_valid_next = held_valid_reg;
        held_width_next = held_width_reg;

        // one emission attempt when allowed to move
        if (attempting && proceed) begin
            if (att_block) begin
                ovf_next      = 1'b1;
                item_ovf_next = 1'b1;
            end else begin
                attempts_next = attempts_reg + 1'b1;
                carry_next    = rnd_carry;
                if (rnd_width != '0) begin
                    held_valid_next = 1'b1;
                    held_width_next = rnd_width;
                    emitted_next    = emitted_reg + 1'b1;
                end
            end
        end

        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    attempts_next   = '0;
                    item_ovf_next   = 1'b0;
                    held_valid_next = 1'b0;
                    case (cmd_data.kind)
                        afsk_pkg::CMD_START: begin
                            tone_mark_next = 1'b1;
                            cur_half_next  = '0;
                            pend_time_next = '0;
                            carry_next     = '0;
                            emitted_next   = '0;
                            ovf_next       = 1'b0;
                        end
                        afsk_pkg::CMD_FLUSH: begin
                            if (!ovf_reg) begin
                                if (pend_time_reg != '0) begin
                                    flush_mode_next = 1'b1;
                                    state_next      = ST_PEND;
                                end else begin
                                    cur_half_next = '0;
                                end
                            end
                        end
                        afsk_pkg::CMD_DATA: begin
                            if (!ovf_reg) begin
                                tone_mark_next = new_tone;
                                if (cur_half_reg == '0) begin
                                    cur_half_next  = new_half;
                                    pend_time_next = '0;
                                    accum_next     = {1'b0, cfg.bit_time};
                                    state_next     = ST_LOOP;
                                end else if (new_half != cur_half_reg) begin
                                    if (pend_time_reg != '0) begin
                                        tgt_half_next   = new_half;
                                        flush_mode_next = 1'b0;
                                        state_next      = ST_PEND;
                                    end else begin
                                        cur_half_next = new_half;
                                        accum_next    = {1'b0, cfg.bit_time};
                                        state_next    = ST_LOOP;
                                    end
                                end else begin
                                    accum_next = {1'b0, pend_time_reg} + {1'b0, cfg.bit_time};
                                    state_next = ST_LOOP;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_PEND: begin
                if (proceed) begin
                    if (att_block) begin
                        state_next = ST_DONE;
                    end else if (flush_mode_reg) begin
                        pend_time_next = '0;
                        cur_half_next  = '0;
                        state_next     = ST_DONE;
                    end else begin
                        cur_half_next  = tgt_half_reg;
                        pend_time_next = '0;
                        accum_next     = {1'b0, cfg.bit_time};
                        state_next     = ST_LOOP;
                    end
                end
            end
            ST_LOOP: begin
                if (!loop_more) begin
                    pend_time_next = accum_reg[TW-1:0];
                    state_next     = ST_DONE;
                end else if (proceed) begin
                    if (att_block) begin
                        state_next = ST_DONE;
                    end else begin
                        accum_next = accum_reg - {1'b0, cur_half_reg};
                    end
                end
            end
            ST_DONE: begin
                if (proceed) begin
                    held_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            tone_mark_reg  <= 1'b1;
            cur_half_reg   <= '0;
            pend_time_reg  <= '0;
            carry_reg      <= '0;
            emitted_reg    <= '0;
            ovf_reg        <= 1'b0;
            item_ovf_reg   <= 1'b0;
            held_valid_reg <= 1'b0;
            attempts_reg   <= '0;
            flush_mode_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            tone_mark_reg  <= tone_mark_next;
            cur_half_reg   <= cur_half_next;
            pend_time_reg  <= pend_time_next;
            carry_reg      <= carry_next;
            emitted_reg    <= emitted_next;
            ovf_reg        <= ovf_next;
            item_ovf_reg   <= item_ovf_next;
            held_valid_reg <= held_valid_next;
            attempts_reg   <= attempts_next;
            flush_mode_reg <= flush_mode_next;
        end
    end

    // working registers, no reset
    always_ff @(posedge aclk) begin
        accum_reg      <= accum_next;
        tgt_half_reg   <= tgt_half_next;
        held_width_reg <= held_width_next;
    end

endmodule

// File: rtl/core/afsk_nrzi_half_cycle_generator.sv
// Flow: the engine takes each input from the front-end queue; a data bit then makes its
// emission attempts (a tone-change flush counts as one, at most MAX_PULSES_PER_ITEM), ends the
// loop or hits a limit, and passes a closing state that sends its last result; a flush with
// pending time passes the pending and closing states, and a start is taken in the idle state.
// A new command is taken only once the last one has closed, and output stalls hold the engine.
// Reset: config registers return to their defaults, tone is mark, timing state and queues clear.
`timescale 1ns / 1ps

module afsk_nrzi_half_cycle_generator #(
    parameter int TIME_FRAC_BITS      = 16,
    parameter int MAX_PULSES_PER_ITEM = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [afsk_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [afsk_pkg::TIME_W-1:0]         cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  afsk_pkg::in_item_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output afsk_pkg::out_item_t                 m_data
);

    afsk_pkg::cfg_t      cfg_reg;
    afsk_pkg::cfg_t      cfg_next;
    logic                cmd_valid;
    logic                cmd_ready;
    afsk_pkg::cmd_t      cmd_data;
    logic                res_valid;
    logic                res_ready;
    afsk_pkg::out_item_t res_data;

    // configuration register writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                afsk_pkg::REG_BIT_TIME:       cfg_next.bit_time   = cfg_wdata;
                afsk_pkg::REG_MARK_HALF:      cfg_next.mark_half  = cfg_wdata;
                afsk_pkg::REG_SPACE_HALF:     cfg_next.space_half = cfg_wdata;
                afsk_pkg::REG_PULSE_CAPACITY:
                    cfg_next.pulse_capacity = cfg_wdata[afsk_pkg::COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.bit_time       <= afsk_pkg::BIT_TIME_RST;
            cfg_reg.mark_half      <= afsk_pkg::MARK_HALF_RST;
            cfg_reg.space_half     <= afsk_pkg::SPACE_HALF_RST;
            cfg_reg.pulse_capacity <= afsk_pkg::PULSE_CAPACITY_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // front end: decode and command queue
    afsk_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_data  (cmd_data)
    );

    // back end: half-cycle engine
    afsk_engine #(
        .FRAC_BITS  (TIME_FRAC_BITS),
        .MAX_PULSES (MAX_PULSES_PER_ITEM)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_data  (cmd_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    // result queue toward the output port
    afsk_queue #(
        .item_t (afsk_pkg::out_item_t),
        .DEPTH  (2)
    ) u_res_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_ready  (res_ready),
        .in_data   (res_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

    // overflow is only ever flagged on the closing result of an item
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_data.overflow || m_data.last))
        else $error("overflow flagged on a result that is not last");

    // the engine holds a stalled result until the queue takes it
    assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && !res_ready) |=> (res_valid && $stable(res_data)))
        else $error("engine result dropped or changed under stall");

    // nothing leaves the block right after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

// File: test/tb.sv
// self-checking testbench for the afsk nrzi half-cycle generator
`timescale 1ns / 1ps

module tb;

    localparam int     FRAC_BITS    = 16;
    localparam int     ITEM_LIMIT   = 16;
    localparam longint ONE_US       = 64'sd1 <<< FRAC_BITS;
    localparam longint HALF_US      = ONE_US / 2;
    localparam longint CARRY_MAX    = (64'sd1 <<< (FRAC_BITS + 1)) - 1;
    localparam longint CARRY_MIN    = -(64'sd1 <<< (FRAC_BITS + 1));
    localparam int     WIDTH_MAX    = 65535;
    localparam int     DRAIN_CYCLES = 40;
    localparam int     STALL_LIMIT  = 1000;
    // selector code the block ignores
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [afsk_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [afsk_pkg::TIME_W-1:0]    cfg_wdata = '0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    afsk_pkg::in_item_t             s_data = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    afsk_pkg::out_item_t            m_data;

    afsk_nrzi_half_cycle_generator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // predictor copy of the registers
    logic [afsk_pkg::TIME_W-1:0]  bit_time_r = afsk_pkg::BIT_TIME_RST;
    logic [afsk_pkg::TIME_W-1:0]  mark_half_r = afsk_pkg::MARK_HALF_RST;
    logic [afsk_pkg::TIME_W-1:0]  space_half_r = afsk_pkg::SPACE_HALF_RST;
    logic [afsk_pkg::COUNT_W-1:0] capacity_r = afsk_pkg::PULSE_CAPACITY_RST;

    // predictor copy of the modulator state
    logic                         tone_mark = 1'b1;
    logic [afsk_pkg::TIME_W-1:0]  cur_half = '0;
    logic [afsk_pkg::TIME_W-1:0]  pend_time = '0;
    longint                       round_rem = 0;
    logic [afsk_pkg::COUNT_W-1:0] pulse_count = '0;
    logic                         frame_ovf = 1'b0;

    // per-item bookkeeping
    int                           n_attempts;
    logic                         item_ovf;
    afsk_pkg::out_item_t          item_widths[$];

    afsk_pkg::in_item_t           cmd_q[$];
    afsk_pkg::out_item_t          expected_widths[$];

    bit  s_fired = 1'b0;
    bit  m_fired = 1'b0;
    bit  steady = 1'b0;
    int  tx_hold = 0;
    int  rx_hold = 0;
    int  quiet_cycles = 0;
    int  err_count = 0;
    int  items_sent = 0;
    int  widths_checked = 0;
    int  settings_used = 1;

    // one emission attempt: round half-to-even with carried remainder
    function automatic bit try_emit(input logic [afsk_pkg::TIME_W-1:0] value);
        longint              v;
        longint              whole;
        longint              rem;
        afsk_pkg::out_item_t r;
        if (n_attempts >= ITEM_LIMIT || pulse_count >= capacity_r) begin
            item_ovf = 1'b1;
            frame_ovf = 1'b1;
            return 1'b0;
        end
        n_attempts++;
        v = longint'({32'd0, value}) + round_rem;
        whole = v >>> FRAC_BITS;
        rem = v - whole * ONE_US;
        if (rem > HALF_US || (rem == HALF_US && (whole & 1) != 0))
            whole++;
        if (whole < 0)
            whole = 0;
        if (whole > WIDTH_MAX)
            whole = WIDTH_MAX;
        rem = v - whole * ONE_US;
        if (rem > CARRY_MAX)
            rem = CARRY_MAX;
        if (rem < CARRY_MIN)
            rem = CARRY_MIN;
        round_rem = rem;
        if (whole != 0) begin
            r.pulse_width = whole[afsk_pkg::WIDTH_W-1:0];
            r.last = 1'b0;
            r.overflow = 1'b0;
            item_widths.push_back(r);
            pulse_count = pulse_count + 1'b1;
        end
        return 1'b1;
    endfunction

    // nrzi data bit: tone change flushes the partial half cycle first
    function automatic void model_bit(input logic b);
        logic [afsk_pkg::TIME_W-1:0] half;
        logic [afsk_pkg::TIME_W:0]   acc;
        if (!b)
            tone_mark = !tone_mark;
        half = tone_mark ? mark_half_r : space_half_r;
        if (cur_half == 0) begin
            cur_half = half;
            pend_time = '0;
        end else if (half != cur_half) begin
            if (pend_time != 0 && !try_emit(pend_time))
                return;
            cur_half = half;
            pend_time = '0;
        end
        acc = {1'b0, pend_time} + {1'b0, bit_time_r};
        while (acc >= {1'b0, cur_half}) begin
            if (!try_emit(cur_half))
                return;
            acc = acc - {1'b0, cur_half};
        end
        pend_time = acc[afsk_pkg::TIME_W-1:0];
    endfunction

    // widths expected for one accepted item
    function automatic void model_half_cycles(input afsk_pkg::in_item_t it);
        afsk_pkg::out_item_t r;
        item_widths.delete();
        n_attempts = 0;
        item_ovf = 1'b0;
        if (it.func == afsk_pkg::FUNC_START) begin
            tone_mark = 1'b1;
            cur_half = '0;
            pend_time = '0;
            round_rem = 0;
            pulse_count = '0;
            frame_ovf = 1'b0;
            return;
        end
        if ((it.func != afsk_pkg::FUNC_DATA && it.func != afsk_pkg::FUNC_FLUSH) || frame_ovf)
            return;
        if (it.func == afsk_pkg::FUNC_DATA) begin
            model_bit(it.bit_req);
        end else if (pend_time == 0 || try_emit(pend_time)) begin
            pend_time = '0;
            cur_half = '0;
        end
        if (item_ovf && item_widths.size() == 0) begin
            r.pulse_width = '0;
            r.last = 1'b1;
            r.overflow = 1'b1;
            item_widths.push_back(r);
        end else if (item_widths.size() > 0) begin
            r = item_widths.pop_back();
            r.last = 1'b1;
            r.overflow = item_ovf;
            item_widths.push_back(r);
        end
        foreach (item_widths[i])
            expected_widths.push_back(item_widths[i]);
    endfunction

    // input driver
    always @(negedge aclk) begin : drive
        logic               nv;
        afsk_pkg::in_item_t nd;
        nv = s_valid;
        nd = s_data;
        if (!aresetn) begin
            nv = 1'b0;
        end else begin
            if (s_fired)
                nv = 1'b0;
            if (!nv) begin
                if (tx_hold > 0) begin
                    tx_hold--;
                end else if (cmd_q.size() > 0) begin
                    if (!steady && $urandom_range(0, 5) == 0) begin
                        tx_hold = $urandom_range(0, 7);
                    end else begin
                        nd = cmd_q.pop_front();
                        nv = 1'b1;
                    end
                end
            end
        end
        s_valid <= nv;
        s_data <= nd;
    end

    // result backpressure
    always @(negedge aclk) begin : sink
        if (rx_hold > 0) begin
            rx_hold--;
            m_ready <= 1'b0;
        end else if (!steady && $urandom_range(0, 5) == 0) begin
            rx_hold = $urandom_range(0, 7);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // monitor, checker and watchdog
    always @(posedge aclk) begin : watch
        afsk_pkg::out_item_t want;
        s_fired = aresetn && s_valid && s_ready;
        m_fired = aresetn && m_valid && m_ready;
        if (m_fired) begin
            if (expected_widths.size() == 0) begin
                $error("unexpected result transfer: pulse_width %0d last %0b overflow %0b",
                       m_data.pulse_width, m_data.last, m_data.overflow);
                err_count++;
            end else begin
                want = expected_widths.pop_front();
                widths_checked++;
                if (m_data.pulse_width !== want.pulse_width) begin
                    $error("pulse_width: expected %0d, actual %0d",
                           want.pulse_width, m_data.pulse_width);
                    err_count++;
                end
                if (m_data.last !== want.last) begin
                    $error("last: expected %0b, actual %0b", want.last, m_data.last);
                    err_count++;
                end
                if (m_data.overflow !== want.overflow) begin
                    $error("overflow: expected %0b, actual %0b", want.overflow, m_data.overflow);
                    err_count++;
                end
            end
        end
        if (s_fired) begin
            items_sent++;
            model_half_cycles(s_data);
        end
        if (s_fired || m_fired)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     quiet_cycles, expected_widths.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic void push_cmd(input logic [1:0] f, input logic b);
        afsk_pkg::in_item_t it;
        it.func = f;
        it.bit_req = b;
        cmd_q.push_back(it);
    endfunction

    // register write while the block is idle
    task automatic write_reg(input logic [afsk_pkg::CFG_IDX_W-1:0] idx,
                             input logic [afsk_pkg::TIME_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            afsk_pkg::REG_BIT_TIME:       bit_time_r = val;
            afsk_pkg::REG_MARK_HALF:      mark_half_r = val;
            afsk_pkg::REG_SPACE_HALF:     space_half_r = val;
            afsk_pkg::REG_PULSE_CAPACITY: capacity_r = val[afsk_pkg::COUNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [afsk_pkg::TIME_W-1:0] bt,
                             input logic [afsk_pkg::TIME_W-1:0] mh,
                             input logic [afsk_pkg::TIME_W-1:0] sh,
                             input logic [afsk_pkg::TIME_W-1:0] cap);
        write_reg(afsk_pkg::REG_BIT_TIME, bt);
        write_reg(afsk_pkg::REG_MARK_HALF, mh);
        write_reg(afsk_pkg::REG_SPACE_HALF, sh);
        write_reg(afsk_pkg::REG_PULSE_CAPACITY, cap);
        settings_used++;
    endtask

    // sender holds off until every expected width has come back
    task automatic wait_drained();
        while (cmd_q.size() != 0 || s_valid || expected_widths.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // mostly whole frames with random bits, some stray commands
    task automatic queue_frames(input int n);
        int k;
        int len;
        k = 0;
        while (k < n) begin
            if ($urandom_range(0, 9) == 0) begin
                push_cmd(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
                k++;
            end else begin
                len = $urandom_range(1, 12);
                if (len > n - k - 1)
                    len = (n - k > 1) ? n - k - 1 : 1;
                push_cmd(afsk_pkg::FUNC_START, 1'($urandom_range(0, 1)));
                repeat (len) push_cmd(afsk_pkg::FUNC_DATA, 1'($urandom_range(0, 1)));
                k += len + 1;
                if ($urandom_range(0, 4) != 0) begin
                    push_cmd(afsk_pkg::FUNC_FLUSH, 1'($urandom_range(0, 1)));
                    k++;
                end
            end
        end
    endtask

    initial begin : stimulus
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        // reset timing: steady tone, tone changes, flushes, ignored selector
        push_cmd(afsk_pkg::FUNC_DATA, 1'b1);
        push_cmd(afsk_pkg::FUNC_DATA, 1'b1);
        push_cmd(afsk_pkg::FUNC_DATA, 1'b0);
        push_cmd(afsk_pkg::FUNC_DATA, 1'b0);
        push_cmd(afsk_pkg::FUNC_DATA, 1'b1);
        push_cmd(afsk_pkg::FUNC_FLUSH, 1'b1);
        push_cmd(afsk_pkg::FUNC_FLUSH, 1'b0);
        push_cmd(FUNC_UNUSED, 1'b0);
        push_cmd(FUNC_UNUSED, 1'b1);
        push_cmd(afsk_pkg::FUNC_DATA, 1'b0);
        push_cmd(afsk_pkg::FUNC_START, 1'b1);
        wait_drained();

        // tiny capacity: overflow marker, then frozen until start
        write_reg(afsk_pkg::REG_PULSE_CAPACITY, 32'd2);
        push_cmd(afsk_pkg::FUNC_START, 1'b0);
        push_cmd(afsk_pkg::FUNC_DATA, 1'b1);
        push_cmd(afsk_pkg::FUNC_DATA, 1'b1);
        push_cmd(afsk_pkg::FUNC_DATA, 1'b0);
        push_cmd(afsk_pkg::FUNC_FLUSH, 1'b0);
        push_cmd(afsk_pkg::FUNC_START, 1'b0);
        wait_drained();

        // capacity of zero, upper write bits dropped
        write_reg(afsk_pkg::REG_PULSE_CAPACITY, 32'hFFFF_0000);
        push_cmd(afsk_pkg::FUNC_DATA, 1'b1);
        wait_drained();

        // extremes: zero mark period, saturating space width, full capacity
        write_all(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'h0000_FFFF);
        push_cmd(afsk_pkg::FUNC_START, 1'b0);
        push_cmd(afsk_pkg::FUNC_DATA, 1'b1);
        push_cmd(afsk_pkg::FUNC_START, 1'b1);
        push_cmd(afsk_pkg::FUNC_DATA, 1'b0);
        push_cmd(afsk_pkg::FUNC_DATA, 1'b0);
        push_cmd(afsk_pkg::FUNC_FLUSH, 1'b1);
        wait_drained();

        // reset timing with a small random capacity
        write_all(afsk_pkg::BIT_TIME_RST, afsk_pkg::MARK_HALF_RST, afsk_pkg::SPACE_HALF_RST,
                  $urandom_range(8, 40));
        queue_frames(58);
        wait_drained();

        // half periods of at most 1.5 us: many dropped widths, carry at work
        steady = 1'b1;
        write_all($urandom_range(0, 32'h6_0000), $urandom_range(1, 32'h1_8000),
                  $urandom_range(1, 32'h1_8000), 32'd4096);
        queue_frames(58);
        wait_drained();

        // exact half fractions to hit ties in the rounding
        steady = 1'b0;
        write_all($urandom_range(1, 60) * 32'h1_0000 + $urandom_range(0, 32'hFFFF),
                  $urandom_range(1, 20) * 32'h1_0000 + 32'h8000,
                  $urandom_range(1, 20) * 32'h1_0000 + 32'h8000, 32'h0000_FFFF);
        queue_frames(58);
        wait_drained();

        // fully random register values
        steady = 1'b1;
        write_all($urandom, $urandom, $urandom, $urandom);
        queue_frames(58);
        wait_drained();

        // audio-rate timing with per-item limit overflows
        steady = 1'b0;
        write_all($urandom_range(20_000_000, 250_000_000), $urandom_range(10_000_000, 80_000_000),
                  $urandom_range(5_000_000, 40_000_000), $urandom_range(1, 4096));
        queue_frames(58);
        wait_drained();

        // closing stretch at reset timing without idling
        steady = 1'b1;
        write_all(afsk_pkg::BIT_TIME_RST, afsk_pkg::MARK_HALF_RST, afsk_pkg::SPACE_HALF_RST,
                  32'(afsk_pkg::PULSE_CAPACITY_RST));
        queue_frames(58);
        wait_drained();

        $display("covered %0d input transfers and %0d checked widths over %0d register settings",
                 items_sent, widths_checked, settings_used);
        $display("including overflow, zero-period, saturation and rounding-tie cases");
        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
